### rtl/bounded_priority_queue_unit_defines.svh
// Assertion macros shared by the priority queue RTL.
`ifndef BOUNDED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define BOUNDED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Concurrent check, switched off while reset is high
`define BPQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds through reset
`define BPQ_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BPQ_ASSERT(label, clk, rst, prop, msg)
`define BPQ_ASSERT_NR(label, clk, prop, msg)

`endif

`endif

### rtl/bpq_pkg.sv
// Types and constants of the bounded priority queue.
`default_nettype none

package bpq_pkg;

  localparam int QUEUE_DEPTH     = 8;
  localparam int PRIORITY_LEVELS = 8;

  // Internal fill counter can hold the depth itself
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  // Reported count field is fixed at four bits
  localparam int COUNT_W = 4;

  // Highest storable priority, limited to the 3-bit field
  localparam logic [2:0] PRIO_MAX =
    (PRIORITY_LEVELS - 1 > 7) ? 3'd7 : 3'(PRIORITY_LEVELS - 1);

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_EXTRACT = 2'd1,
    ACT_PURGE   = 2'd2,
    ACT_QUERY   = 2'd3
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [7:0]  task_id;
    logic [2:0]  priority_req;
    logic [31:0] payload;
  } cmd_t;

  typedef struct packed {
    logic               success;
    logic [7:0]         out_task;
    logic [31:0]        out_payload;
    logic [COUNT_W-1:0] count;
  } result_t;

  // One queue slot; task id 0 marks an empty slot
  typedef struct packed {
    logic [7:0]  task_id;
    logic [2:0]  prio;
    logic [31:0] payload;
  } entry_t;

  // Per-cell control: take the neighbour above, or load the new entry
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/bpq_cell.sv
// One slot of the queue chain: holds an entry, shifts from its upper neighbour.
`default_nettype none

module bpq_cell (
  input  logic                clk,
  input  logic                rst,
  input  bpq_pkg::cell_ctrl_t ctrl,
  input  bpq_pkg::entry_t     shift_in,
  input  bpq_pkg::entry_t     load_in,
  input  logic [7:0]          key,
  output bpq_pkg::entry_t     entry,
  output logic                occ,
  output logic                match
);

  logic [7:0]  held_task;
  logic [2:0]  held_prio;
  logic [31:0] held_payload;

  // Task and priority carry the empty marking, so they are reset
  always_ff @(posedge clk) begin
    if (rst) begin
      held_task <= '0;
      held_prio <= '0;
    end else if (ctrl.shift) begin
      held_task <= shift_in.task_id;
      held_prio <= shift_in.prio;
    end else if (ctrl.load) begin
      held_task <= load_in.task_id;
      held_prio <= load_in.prio;
    end
  end

  // Payload word is only read from occupied slots
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      held_payload <= shift_in.payload;
    end else if (ctrl.load) begin
      held_payload <= load_in.payload;
    end
  end

  assign entry.task_id = held_task;
  assign entry.prio    = held_prio;
  assign entry.payload = held_payload;

  // Occupancy and task compare; task 0 never matches
  assign occ   = (held_task != 8'd0);
  assign match = occ && (held_task == key);

endmodule

`default_nettype wire

### rtl/bpq_select.sv
// Picks the slot to remove and the range of cells that shift down behind it.
`default_nettype none

module bpq_select (
  input  logic                            is_extract,
  input  logic [bpq_pkg::QUEUE_DEPTH-1:0] occ,
  input  logic [bpq_pkg::QUEUE_DEPTH-1:0] match,
  input  logic [2:0]                      prio [bpq_pkg::QUEUE_DEPTH],
  output logic [bpq_pkg::QUEUE_DEPTH-1:0] sel,
  output logic [bpq_pkg::QUEUE_DEPTH-1:0] shift
);

  logic [bpq_pkg::QUEUE_DEPTH-1:0] best;
  logic [bpq_pkg::QUEUE_DEPTH-1:0] first;

  // Highest priority wins; on a tie the lowest slot (oldest) wins
  always_comb begin
    logic beat;
    for (int i = 0; i < bpq_pkg::QUEUE_DEPTH; i++) begin
      beat = occ[i];
      for (int j = 0; j < bpq_pkg::QUEUE_DEPTH; j++) begin
        if (j < i && occ[j] && prio[j] >= prio[i]) begin
          beat = 1'b0;
        end
        if (j > i && occ[j] && prio[j] > prio[i]) begin
          beat = 1'b0;
        end
      end
      best[i] = beat;
    end
  end

  // Lowest matching slot for a purge step
  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < bpq_pkg::QUEUE_DEPTH; i++) begin
      first[i] = match[i] && !seen;
      seen     = seen || match[i];
    end
  end

  assign sel = is_extract ? best : first;

  // Cells at and above the removed slot take their upper neighbour
  always_comb begin
    logic acc;
    acc = 1'b0;
    for (int i = 0; i < bpq_pkg::QUEUE_DEPTH; i++) begin
      acc      = acc || sel[i];
      shift[i] = acc;
    end
  end

endmodule

`default_nettype wire

### rtl/bounded_priority_queue_unit.sv
// Top level of the bounded priority queue: command sequencer over a chain of slot cells.
//
//  channel  | handshake              | word
//  ---------+------------------------+-----------------------------
//  command  | start (in), busy (out) | cmd    : action, task, prio, payload
//  result   | done strobe (out)      | result : success, task, payload, count
//
// Insert, extract and query enter S_RUN on the accepting edge; S_RUN registers the
// result and done and returns to S_IDLE. A new command is taken only in S_IDLE.
// Purge stays in S_RUN while any slot matches: the cell chain drops the lowest
// matching slot once per cycle, and the result is registered once none is left.
// rst is synchronous; it empties the queue and clears busy and done.
// done is high for one cycle only; the receiver cannot stall it.
`default_nettype none
`include "bounded_priority_queue_unit_defines.svh"

module bounded_priority_queue_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bpq_pkg::cmd_t     cmd,
  output logic              busy,
  output logic              done,
  output bpq_pkg::result_t  result
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t                          state;
  bpq_pkg::cmd_t                   cmd_q;
  logic [bpq_pkg::CNT_W-1:0]       count;
  logic [bpq_pkg::CNT_W-1:0]       count_next;
  logic                            found;
  logic                            found_next;
  logic                            fin;
  bpq_pkg::result_t                res_next;

  bpq_pkg::entry_t                 cell_q   [bpq_pkg::QUEUE_DEPTH];
  bpq_pkg::cell_ctrl_t             ctrl     [bpq_pkg::QUEUE_DEPTH];
  logic [2:0]                      cell_prio[bpq_pkg::QUEUE_DEPTH];
  logic [bpq_pkg::QUEUE_DEPTH-1:0] occ;
  logic [bpq_pkg::QUEUE_DEPTH-1:0] match;
  logic [bpq_pkg::QUEUE_DEPTH-1:0] sel;
  logic [bpq_pkg::QUEUE_DEPTH-1:0] shift;
  bpq_pkg::entry_t                 ins_entry;
  bpq_pkg::entry_t                 pick;
  logic                            ins_ok;
  logic                            is_extract;

  // Command word held for the whole operation
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_q <= cmd;
    end
  end

  // New entry with priority clamped to the level range
  always_comb begin
    ins_entry.task_id = cmd_q.task_id;
    ins_entry.prio    = (cmd_q.priority_req > bpq_pkg::PRIO_MAX) ?
                        bpq_pkg::PRIO_MAX : cmd_q.priority_req;
    ins_entry.payload = cmd_q.payload;
  end

  assign ins_ok     = (cmd_q.task_id != 8'd0) &&
                      (count < bpq_pkg::CNT_W'(bpq_pkg::QUEUE_DEPTH));
  assign is_extract = (cmd_q.action == bpq_pkg::ACT_EXTRACT);

  // Cell chain; the top cell shifts in an empty slot
  for (genvar g = 0; g < bpq_pkg::QUEUE_DEPTH; g++) begin : g_cell
    bpq_pkg::entry_t up;
    if (g < bpq_pkg::QUEUE_DEPTH - 1) begin : g_mid
      assign up = cell_q[g + 1];
    end else begin : g_top
      assign up = '0;
    end

    bpq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl[g]),
      .shift_in (up),
      .load_in  (ins_entry),
      .key      (cmd_q.task_id),
      .entry    (cell_q[g]),
      .occ      (occ[g]),
      .match    (match[g])
    );

    assign cell_prio[g] = cell_q[g].prio;
  end

  bpq_select u_select (
    .is_extract (is_extract),
    .occ        (occ),
    .match      (match),
    .prio       (cell_prio),
    .sel        (sel),
    .shift      (shift)
  );

  // Selected entry for extract (sel is one-hot)
  always_comb begin
    pick = '0;
    for (int i = 0; i < bpq_pkg::QUEUE_DEPTH; i++) begin
      if (sel[i]) begin
        pick = cell_q[i];
      end
    end
  end

  // Operation step: cell controls, next count and result word
  always_comb begin
    count_next = count;
    found_next = found;
    fin        = 1'b1;
    res_next   = '0;
    for (int i = 0; i < bpq_pkg::QUEUE_DEPTH; i++) begin
      ctrl[i] = '0;
    end
    if (state == S_RUN) begin
      case (cmd_q.action)
        bpq_pkg::ACT_INSERT: begin
          if (ins_ok) begin
            for (int i = 0; i < bpq_pkg::QUEUE_DEPTH; i++) begin
              ctrl[i].load = (count == bpq_pkg::CNT_W'(i));
            end
            count_next       = count + 1'b1;
            res_next.success = 1'b1;
          end
        end
        bpq_pkg::ACT_EXTRACT: begin
          if (count != '0) begin
            for (int i = 0; i < bpq_pkg::QUEUE_DEPTH; i++) begin
              ctrl[i].shift = shift[i];
            end
            count_next           = count - 1'b1;
            res_next.success     = 1'b1;
            res_next.out_task    = pick.task_id;
            res_next.out_payload = pick.payload;
          end
        end
        bpq_pkg::ACT_PURGE: begin
          if (|match) begin
            for (int i = 0; i < bpq_pkg::QUEUE_DEPTH; i++) begin
              ctrl[i].shift = shift[i];
            end
            count_next = count - 1'b1;
            found_next = 1'b1;
            fin        = 1'b0;
          end else begin
            res_next.success = found;
          end
        end
        bpq_pkg::ACT_QUERY: begin
          res_next.success = |match;
        end
        default: begin
          res_next.success = 1'b0;
        end
      endcase
    end
    res_next.count = bpq_pkg::COUNT_W'(count_next);
  end

  // Sequencer with registered handshake and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      busy   <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
      found  <= 1'b0;
      result <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_RUN;
            busy  <= 1'b1;
            found <= 1'b0;
          end
        end
        S_RUN: begin
          count <= count_next;
          found <= found_next;
          if (fin) begin
            state  <= S_IDLE;
            busy   <= 1'b0;
            done   <= 1'b1;
            result <= res_next;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

  // Checks
  `BPQ_ASSERT(a_done_not_busy, clk, rst, done |-> !busy, "result strobe while busy")
  `BPQ_ASSERT(a_count_range, clk, rst, count <= bpq_pkg::CNT_W'(bpq_pkg::QUEUE_DEPTH), "count over depth")
  `BPQ_ASSERT(a_occ_packed, clk, rst, (occ & (occ + 1'b1)) == '0, "occupied slots not packed")
  `BPQ_ASSERT(a_count_occ, clk, rst, $countones(occ) == int'(count), "count differs from occupancy")
  `BPQ_ASSERT_NR(a_accept_busy, clk, (start && !busy && !rst) |=> busy, "busy not raised on accept")

endmodule

`default_nettype wire

### tb/bounded_priority_queue_unit_tb.sv
// Self-checking testbench for the bounded priority queue: directed and random command words.
`timescale 1ns / 1ps

module bounded_priority_queue_unit_tb;
  import bpq_pkg::*;

  // Pending command word with the sender's idle chance for its slot
  typedef struct {
    cmd_t        word;
    int unsigned idle_pct;
  } pending_t;

  logic    clk;
  logic    rst   = 1'b1;
  logic    start = 1'b0;
  cmd_t    cmd   = '0;
  logic    busy;
  logic    done;
  result_t result;

  pending_t    cmd_q[$];
  result_t     want_q[$];
  int unsigned mismatches = 0;

  // Shadow copy of the queue contents, kept in insertion order
  logic [7:0]  shadow_task[QUEUE_DEPTH];
  logic [2:0]  shadow_prio[QUEUE_DEPTH];
  logic [31:0] shadow_payload[QUEUE_DEPTH];
  int          shadow_fill = 0;

  bounded_priority_queue_unit dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("bounded_priority_queue_unit_tb failed");
    $finish;
  end

  // Take out one occupied slot; later entries move down by one
  function automatic void shadow_remove(int idx);
    for (int j = idx; j + 1 < shadow_fill; j++) begin
      shadow_task[j]    = shadow_task[j + 1];
      shadow_prio[j]    = shadow_prio[j + 1];
      shadow_payload[j] = shadow_payload[j + 1];
    end
    shadow_fill--;
    shadow_task[shadow_fill] = '0;
    shadow_prio[shadow_fill] = '0;
  endfunction

  // Apply one accepted command to the shadow queue and return the result it yields
  function automatic result_t queue_outcome(cmd_t c);
    result_t    r;
    logic [2:0] p;
    int         best;
    int         i;
    r = '0;
    case (c.action)
      ACT_INSERT: begin
        if (c.task_id != 8'd0 && shadow_fill < QUEUE_DEPTH) begin
          p = c.priority_req;
          if (int'(p) > PRIORITY_LEVELS - 1) p = 3'(PRIORITY_LEVELS - 1);
          shadow_task[shadow_fill]    = c.task_id;
          shadow_prio[shadow_fill]    = p;
          shadow_payload[shadow_fill] = c.payload;
          shadow_fill++;
          r.success = 1'b1;
        end
      end
      ACT_EXTRACT: begin
        // highest priority wins; on a tie the lowest slot (oldest) wins
        if (shadow_fill > 0) begin
          best = 0;
          for (int k = 1; k < shadow_fill; k++)
            if (shadow_prio[k] > shadow_prio[best]) best = k;
          r.out_task    = shadow_task[best];
          r.out_payload = shadow_payload[best];
          r.success     = 1'b1;
          shadow_remove(best);
        end
      end
      ACT_PURGE: begin
        i = 0;
        while (i < shadow_fill) begin
          if (c.task_id != 8'd0 && shadow_task[i] == c.task_id) begin
            shadow_remove(i);
            r.success = 1'b1;
          end else begin
            i++;
          end
        end
      end
      default: begin
        for (int k = 0; k < shadow_fill; k++)
          if (c.task_id != 8'd0 && shadow_task[k] == c.task_id) r.success = 1'b1;
      end
    endcase
    r.count = COUNT_W'(shadow_fill);
    return r;
  endfunction

  task automatic queue_cmd(action_t a, logic [7:0] t, logic [2:0] p, logic [31:0] d,
                           int unsigned idle);
    pending_t w;
    w.word.action       = a;
    w.word.task_id      = t;
    w.word.priority_req = p;
    w.word.payload      = d;
    w.idle_pct          = idle;
    cmd_q.push_back(w);
  endtask

  // Mostly a handful of busy task ids so purge and query hit; some zero, some anything
  function automatic logic [7:0] pick_task_id();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 8'd0;
    if (r < 25) return 8'($urandom_range(255));
    return 8'($urandom_range(6, 1));
  endfunction

  function automatic logic [31:0] pick_payload();
    int unsigned r;
    r = $urandom_range(19);
    if (r == 0) return 32'd0;
    if (r == 1) return 32'hFFFF_FFFF;
    return 32'($urandom);
  endfunction

  // Random words in blocks; each block leans towards filling or draining the queue
  task automatic queue_random(int n, int unsigned idle);
    int unsigned ins_weight;
    int unsigned r;
    action_t     a;
    ins_weight = 50;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) ins_weight = $urandom_range(75, 20);
      r = $urandom_range(99);
      if (r < ins_weight) begin
        a = ACT_INSERT;
      end else begin
        r = $urandom_range(99);
        if (r < 45)      a = ACT_EXTRACT;
        else if (r < 75) a = ACT_QUERY;
        else             a = ACT_PURGE;
      end
      queue_cmd(a, pick_task_id(), 3'($urandom_range(7)), pick_payload(), idle);
    end
  endtask

  // Command driver: hold a word while busy, otherwise offer the next one or idle
  always @(posedge clk) begin : cmd_drive
    pending_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) want_q.push_back(queue_outcome(cmd));
      if (start && busy) begin
        // word still waiting to be taken
      end else if (cmd_q.size() != 0 && $urandom_range(99) >= cmd_q[0].idle_pct) begin
        nxt = cmd_q.pop_front();
        start <= 1'b1;
        cmd   <= nxt.word;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor: each strobed word against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && done === 1'b1) begin
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: success=%0b task=%0d payload=%h count=%0d",
                   result.success, result.out_task, result.out_payload, result.count);
      end else begin
        want = want_q.pop_front();
        if (result.success !== want.success || result.out_task !== want.out_task ||
            result.out_payload !== want.out_payload || result.count !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: want success=%0b task=%0d payload=%h count=%0d, got success=%0b task=%0d payload=%h count=%0d",
                     want.success, want.out_task, want.out_payload, want.count,
                     result.success, result.out_task, result.out_payload, result.count);
        end
      end
    end
  end

  initial begin
    // directed: empty, refusals, full, ties, purge of slot 0 and neighbours
    queue_cmd(ACT_EXTRACT, 8'd0,   3'd0, 32'd0,          0);
    queue_cmd(ACT_INSERT,  8'd0,   3'd7, 32'hFFFF_FFFF,  0);
    queue_cmd(ACT_INSERT,  8'd5,   3'd3, 32'd0,          0);
    queue_cmd(ACT_INSERT,  8'd5,   3'd3, 32'hFFFF_FFFF,  0);
    queue_cmd(ACT_INSERT,  8'd255, 3'd7, 32'hA5A5_A5A5,  0);
    queue_cmd(ACT_INSERT,  8'd9,   3'd0, 32'h5A5A_5A5A,  0);
    queue_cmd(ACT_INSERT,  8'd5,   3'd7, 32'd1,          0);
    queue_cmd(ACT_INSERT,  8'd1,   3'd3, 32'd2,          0);
    queue_cmd(ACT_INSERT,  8'd9,   3'd7, 32'd3,          0);
    queue_cmd(ACT_INSERT,  8'd200, 3'd1, 32'd4,          0);
    queue_cmd(ACT_INSERT,  8'd7,   3'd2, 32'h1234_5678,  0);
    queue_cmd(ACT_QUERY,   8'd5,   3'd0, 32'd0,          0);
    queue_cmd(ACT_QUERY,   8'd0,   3'd0, 32'd0,          0);
    queue_cmd(ACT_QUERY,   8'd77,  3'd0, 32'd0,          0);
    queue_cmd(ACT_EXTRACT, 8'd0,   3'd0, 32'd0,          0);
    queue_cmd(ACT_PURGE,   8'd5,   3'd0, 32'd0,          0);
    queue_cmd(ACT_PURGE,   8'd0,   3'd0, 32'd0,          0);
    queue_cmd(ACT_PURGE,   8'd77,  3'd0, 32'd0,          0);
    for (int k = 0; k < 5; k++) queue_cmd(ACT_EXTRACT, 8'd0, 3'd0, 32'd0, 0);
    queue_cmd(ACT_QUERY,   8'd9,   3'd0, 32'd0,          0);

    // random phases: no idling, heavy sender idling, none again, lighter idling
    queue_random(375, 0);
    queue_random(375, 73);
    queue_random(375, 0);
    queue_random(375, 37);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || start) @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
    // longest purge drains the whole queue
    repeat (16) @(posedge clk);

    if (mismatches == 0 && want_q.size() == 0) begin
      $display("bounded_priority_queue_unit_tb passed");
    end else begin
      $display("bounded_priority_queue_unit_tb failed");
    end
    $finish;
  end

endmodule
